### rtl/rabs_pkg.sv
// ---------------------------------------------------------------------------
// rabs_pkg
// Shared types and constants for the running-average background subtractor.
// ---------------------------------------------------------------------------
package rabs_pkg;

	// Channel and field widths
	localparam int PIX_W   = 8;
	localparam int INDEX_W = 19;
	localparam int RATE_W  = 8;

	// Width used while reducing a raster index into the store range
	localparam int MOD_W = 24;

	// Learning rate used after reset and in place of a zero rate
	localparam logic [RATE_W-1:0] DEFAULT_RATE = 8'd10;

	// Three colour channels, red in element 0, blue in element 2
	typedef logic [2:0][PIX_W-1:0] rgb_t;

	// What the back end does with one request
	typedef enum logic [1:0] {
		KIND_ZERO  = 2'd0,  // no background yet, answer with zeros
		KIND_COPY  = 2'd1,  // first frame, copy pixel into the store
		KIND_BLEND = 2'd2,  // blend pixel into the stored background
		KIND_READ  = 2'd3   // compare against the stored background only
	} kind_t;

	localparam int KIND_W = $bits(kind_t);

endpackage

### rtl/rabs_queue.sv
// ---------------------------------------------------------------------------
// rabs_queue
// Small first-in first-out queue between the classifying front end and the
// background update back end.
// ---------------------------------------------------------------------------
module rabs_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_data = slot_q[rd_ptr_q];

	// Hold pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the incoming request
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/rabs_front.sv
// ---------------------------------------------------------------------------
// rabs_front
// Accepts pixels, classifies each request against the background state and
// folds the raster index into the store range over two stages.
// ---------------------------------------------------------------------------
module rabs_front import rabs_pkg::*; #(
	parameter int MAX_PIXELS = 524288,
	parameter int IDX_W      = 19
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  rgb_t               in_pix,
	input  logic [INDEX_W-1:0] in_index,
	input  logic               in_last,
	input  logic               in_update,
	input  logic               fifo_full,
	output logic               push,
	output kind_t              push_kind,
	output rgb_t               push_pix,
	output logic [IDX_W-1:0]   push_idx
);

	// Index modulo MAX_PIXELS by reciprocal multiply; the quotient may be one
	// short, so a single compare and subtract finishes the remainder.
	localparam int              SHIFT      = INDEX_W + $clog2(MAX_PIXELS);
	localparam logic [63:0]     RECIP_FULL = (64'd1 << SHIFT) / 64'(MAX_PIXELS);
	localparam int              RECIP_W    = INDEX_W + 1;
	localparam logic [RECIP_W-1:0] RECIP   = RECIP_FULL[RECIP_W-1:0];
	localparam int              PROD_W     = INDEX_W + RECIP_W;
	localparam int              QM_W       = INDEX_W + MOD_W;
	localparam logic [MOD_W-1:0] MAX_M     = MOD_W'(MAX_PIXELS);

	logic               accept;
	logic               advance;
	logic               bg_valid_q;
	kind_t              kind_in;

	logic               valid_s1;
	kind_t              kind_s1;
	rgb_t               pix_s1;
	logic [INDEX_W-1:0] index_s1;
	logic [PROD_W-1:0]  prod_s1;

	logic               valid_s2;
	kind_t              kind_s2;
	rgb_t               pix_s2;
	logic [INDEX_W-1:0] index_s2;
	logic [MOD_W-1:0]   qm_s2;

	logic [INDEX_W-1:0] quot;
	logic [QM_W-1:0]    qm_full;
	logic [MOD_W-1:0]   rem_raw;
	logic [MOD_W-1:0]   rem;

	assign advance  = !valid_s2 || !fifo_full;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;

	// Classify the request in arrival order
	always_comb begin
		if (!bg_valid_q) begin
			kind_in = in_update ? KIND_COPY : KIND_ZERO;
		end else begin
			kind_in = in_update ? KIND_BLEND : KIND_READ;
		end
	end

	// Mark the background as present once the first frame has been copied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_valid_q <= 1'b0;
		end else if (accept && in_update && in_last) begin
			bg_valid_q <= 1'b1;
		end
	end

	// Advance stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	// Quotient estimate and its product with the store depth
	assign quot    = INDEX_W'(prod_s1 >> SHIFT);
	assign qm_full = QM_W'(quot) * QM_W'(MAX_M);

	// Advance stage payloads
	always_ff @(posedge clk) begin
		if (advance) begin
			kind_s1  <= kind_in;
			pix_s1   <= in_pix;
			index_s1 <= in_index;
			prod_s1  <= PROD_W'(in_index) * PROD_W'(RECIP);
			kind_s2  <= kind_s1;
			pix_s2   <= pix_s1;
			index_s2 <= index_s1;
			qm_s2    <= qm_full[MOD_W-1:0];
		end
	end

	// Finish the remainder and hand the request on
	assign rem_raw   = MOD_W'(index_s2) - qm_s2;
	assign rem       = (rem_raw >= MAX_M) ? rem_raw - MAX_M : rem_raw;
	assign push      = valid_s2 && !fifo_full;
	assign push_kind = kind_s2;
	assign push_pix  = pix_s2;
	assign push_idx  = rem[IDX_W-1:0];

endmodule

### rtl/rabs_back.sv
// ---------------------------------------------------------------------------
// rabs_back
// Reads the background entry, blends or copies the pixel into it, writes it
// back and forms the distance and rounded background for the result.
// ---------------------------------------------------------------------------
module rabs_back import rabs_pkg::*; #(
	parameter int MAX_PIXELS = 524288,
	parameter int FRAC_BITS  = 8,
	parameter int IDX_W      = 19
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [RATE_W-1:0] rate,
	input  logic              fifo_empty,
	output logic              pop,
	input  kind_t             head_kind,
	input  rgb_t              head_pix,
	input  logic [IDX_W-1:0]  head_idx,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  out_distance,
	output rgb_t              out_bg,
	output logic              out_ready_res
);

	localparam int BG_W   = PIX_W + FRAC_BITS;
	localparam int SUM_W  = BG_W + RATE_W + 1;
	localparam int DIST_W = BG_W + 3;
	localparam int RND_W  = BG_W + 1;
	localparam logic [SUM_W-1:0]  BLEND_HALF = SUM_W'(1) << (RATE_W - 1);
	localparam logic [SUM_W-1:0]  RATE_ONE   = SUM_W'(1) << RATE_W;
	localparam logic [DIST_W-1:0] DIST_HALF  = DIST_W'(1) << (FRAC_BITS - 1);
	localparam logic [RND_W-1:0]  RND_HALF   = RND_W'(1) << (FRAC_BITS - 1);
	localparam logic [PIX_W-1:0]  PIX_MAX    = '1;

	typedef logic [2:0][BG_W-1:0] bg_word_t;

	logic                 adv;
	logic                 wr_en;

	bg_word_t             mem [MAX_PIXELS];
	bg_word_t             rdata_q;

	logic                 valid_s1;
	kind_t                kind_s1;
	rgb_t                 pix_s1;
	logic [IDX_W-1:0]     idx_s1;

	logic                 fwd_valid_q;
	logic [IDX_W-1:0]     fwd_idx_q;
	bg_word_t             fwd_data_q;

	bg_word_t             bg_old;
	bg_word_t             bg_new;
	bg_word_t             pix_fx;
	logic [SUM_W-1:0]     inv_rate;
	logic [SUM_W-1:0]     blend_sum [3];

	logic                 valid_s2;
	kind_t                kind_s2;
	rgb_t                 pix_s2;
	bg_word_t             bg_s2;

	logic [BG_W-1:0]      diff [3];
	logic [DIST_W-1:0]    dist_sum;
	logic [DIST_W-1:0]    dist_shift;
	logic [PIX_W-1:0]     dist_sat;
	logic [RND_W-1:0]     rnd [3];
	rgb_t                 bg_rnd;
	logic [BG_W-1:0]      pix_fx2 [3];

	logic                 out_valid_q;
	logic [PIX_W-1:0]     distance_q;
	rgb_t                 bg_out_q;
	logic                 ready_res_q;

	// One enable moves the whole back end; it stalls only on the output
	assign adv   = !out_valid_q || out_ready;
	assign pop   = adv && !fifo_empty;
	assign wr_en = adv && valid_s1 && ((kind_s1 == KIND_COPY) || (kind_s1 == KIND_BLEND));

	// Background store: read at the head of the queue, write from stage one
	always_ff @(posedge clk) begin
		if (adv) begin
			rdata_q <= mem[head_idx];
		end
		if (wr_en) begin
			mem[idx_s1] <= bg_new;
		end
	end

	// Keep the latest write, which the store read may have missed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_valid_q <= 1'b0;
		end else if (wr_en) begin
			fwd_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			fwd_idx_q  <= idx_s1;
			fwd_data_q <= bg_new;
		end
	end

	// Stage one: select the newest background and blend
	assign bg_old   = (fwd_valid_q && (fwd_idx_q == idx_s1)) ? fwd_data_q : rdata_q;
	assign inv_rate = RATE_ONE - SUM_W'(rate);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			pix_fx[c]    = BG_W'(pix_s1[c]) << FRAC_BITS;
			blend_sum[c] = SUM_W'(bg_old[c]) * inv_rate
				+ SUM_W'(pix_fx[c]) * SUM_W'(rate) + BLEND_HALF;
		end
		case (kind_s1)
			KIND_COPY: begin
				bg_new = pix_fx;
			end
			KIND_BLEND: begin
				for (int c = 0; c < 3; c++) begin
					bg_new[c] = BG_W'(blend_sum[c] >> RATE_W);
				end
			end
			default: begin
				bg_new = bg_old;
			end
		endcase
	end

	// Advance stage valids and the output flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= !fifo_empty;
			valid_s2    <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	// Stage two: distance and rounded background
	always_comb begin
		dist_sum = '0;
		for (int c = 0; c < 3; c++) begin
			pix_fx2[c] = BG_W'(pix_s2[c]) << FRAC_BITS;
			diff[c]    = (bg_s2[c] > pix_fx2[c]) ? bg_s2[c] - pix_fx2[c]
				: pix_fx2[c] - bg_s2[c];
			dist_sum   = dist_sum + DIST_W'(diff[c]);
			rnd[c]     = (RND_W'(bg_s2[c]) + RND_HALF) >> FRAC_BITS;
			bg_rnd[c]  = (rnd[c] > RND_W'(PIX_MAX)) ? PIX_MAX : rnd[c][PIX_W-1:0];
		end
		dist_shift = (dist_sum + DIST_HALF) >> FRAC_BITS;
		dist_sat   = (dist_shift > DIST_W'(PIX_MAX)) ? PIX_MAX : dist_shift[PIX_W-1:0];
	end

	// Advance payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s1 <= head_kind;
			pix_s1  <= head_pix;
			idx_s1  <= head_idx;
			kind_s2 <= kind_s1;
			pix_s2  <= pix_s1;
			bg_s2   <= bg_new;
			if (kind_s2 == KIND_ZERO) begin
				distance_q  <= '0;
				bg_out_q    <= '0;
				ready_res_q <= 1'b0;
			end else begin
				distance_q  <= dist_sat;
				bg_out_q    <= bg_rnd;
				ready_res_q <= 1'b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign out_distance  = distance_q;
	assign out_bg        = bg_out_q;
	assign out_ready_res = ready_res_q;

endmodule

### rtl/running_average_background_subtract_top.sv
// ---------------------------------------------------------------------------
// running_average_background_subtract_top
// Running-average background subtraction over an RGB pixel stream.
// ---------------------------------------------------------------------------
// The block takes one pixel per clock while the output is not held and
// returns one result per pixel, in order. Each pixel owns one background
// entry, chosen by its raster index modulo MAX_PIXELS, kept per channel in
// unsigned fixed point with FRAC_BITS fraction bits. The sustained rate of
// one pixel per cycle is set by the background store, which can be read and
// written in the same cycle, and by the blend of stage one, which forwards
// the latest write so that pixels of the same index may follow each other
// directly. Until the first frame has been stored (an update carrying the
// last-pixel mark), pixels without the update flag give an all-zero result.
// The store is not cleared at reset; an entry must be written in the first
// frame before it is read. The user must write blend_rate only while the
// block is idle; the block itself does not enforce this. Zero selects the
// default rate of 10.
// ---------------------------------------------------------------------------
module running_average_background_subtract_top import rabs_pkg::*; #(
	parameter int MAX_PIXELS = 524288,
	parameter int FRAC_BITS  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	// Pixel stream in
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_index
	input  logic              s_axis_tlast,   // last_pixel
	input  logic              s_axis_tuser,   // update_background
	// Result stream out
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [31:0]       m_axis_tdata,   // distance, background_red, _green, _blue
	output logic              m_axis_tuser,   // ready_res
	// Blend rate register
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [RATE_W-1:0] cfg_data
);

	localparam int IDX_W    = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
	localparam int ITEM_W   = KIND_W + $bits(rgb_t) + IDX_W;
	localparam int Q_DEPTH  = 4;

	logic [RATE_W-1:0] rate_q;
	logic [RATE_W-1:0] rate_eff;

	rgb_t              in_pix;
	logic              fifo_full;
	logic              fifo_empty;
	logic              push;
	logic              pop;
	kind_t             push_kind;
	rgb_t              push_pix;
	logic [IDX_W-1:0]  push_idx;
	logic [ITEM_W-1:0] head_data;
	kind_t             head_kind;
	rgb_t              head_pix;
	logic [IDX_W-1:0]  head_idx;
	logic [PIX_W-1:0]  res_distance;
	rgb_t              res_bg;
	logic              res_ready;

	// Hold the blend rate
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= DEFAULT_RATE;
		end else if (cfg_valid && cfg_ready) begin
			rate_q <= cfg_data;
		end
	end

	assign rate_eff = (rate_q == '0) ? DEFAULT_RATE : rate_q;

	// Unpack the pixel
	assign in_pix[0] = s_axis_tdata[7:0];
	assign in_pix[1] = s_axis_tdata[15:8];
	assign in_pix[2] = s_axis_tdata[23:16];

	rabs_front #(
		.MAX_PIXELS (MAX_PIXELS),
		.IDX_W      (IDX_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_pix    (in_pix),
		.in_index  (s_axis_tdata[42:24]),
		.in_last   (s_axis_tlast),
		.in_update (s_axis_tuser),
		.fifo_full (fifo_full),
		.push      (push),
		.push_kind (push_kind),
		.push_pix  (push_pix),
		.push_idx  (push_idx)
	);

	rabs_queue #(
		.WIDTH (ITEM_W),
		.DEPTH (Q_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_kind, push_pix, push_idx}),
		.pop       (pop),
		.head_data (head_data),
		.full      (fifo_full),
		.empty     (fifo_empty)
	);

	assign head_kind = kind_t'(head_data[ITEM_W-1 -: KIND_W]);
	assign head_pix  = head_data[IDX_W +: $bits(rgb_t)];
	assign head_idx  = head_data[IDX_W-1:0];

	rabs_back #(
		.MAX_PIXELS (MAX_PIXELS),
		.FRAC_BITS  (FRAC_BITS),
		.IDX_W      (IDX_W)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.rate          (rate_eff),
		.fifo_empty    (fifo_empty),
		.pop           (pop),
		.head_kind     (head_kind),
		.head_pix      (head_pix),
		.head_idx      (head_idx),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_distance  (res_distance),
		.out_bg        (res_bg),
		.out_ready_res (res_ready)
	);

	// Pack the result
	assign m_axis_tdata = {res_bg[2], res_bg[1], res_bg[0], res_distance};
	assign m_axis_tuser = res_ready;

endmodule

### dv/rabs_result_checker.sv
// ---------------------------------------------------------------------------
// rabs_result_checker
// Predicts and checks every result of the background subtractor.
// ---------------------------------------------------------------------------
// Watches the pixel, result and rate channels. Each accepted pixel request
// is run through a local model of the per-pixel background store, and the
// expected answer is queued. Each accepted result is compared field by field
// with the oldest queued answer. Failures are counted and handed upward.
// ---------------------------------------------------------------------------
module rabs_result_checker import rabs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	input  logic              s_axis_tready,
	input  logic [47:0]       s_axis_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_index
	input  logic              s_axis_tlast,   // last_pixel
	input  logic              s_axis_tuser,   // update_background
	input  logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	input  logic [31:0]       m_axis_tdata,   // distance, background_red, _green, _blue
	input  logic              m_axis_tuser,   // ready_res
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [RATE_W-1:0] cfg_data,
	output int                fail_count,
	output int                answers_due,
	output int                answers_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC        = 8;
	localparam int STORE_DEPTH = 524288;
	localparam int SHOW_LIMIT  = 10;

	// Background colour, one Q8.8 value per channel, red in element 0
	typedef logic [2:0][15:0] fix_rgb_t;

	// One result: ready flag on top, then the colour, distance lowest
	typedef struct packed {
		logic             ready;
		rgb_t             colour;
		logic [PIX_W-1:0] distance;
	} answer_t;

	fix_rgb_t          bg_model [int unsigned];
	logic              bg_ready;
	logic [RATE_W-1:0] rate;
	answer_t           pending_answers [$];

	// Round a Q8.8 value half up and clip it to one byte
	function automatic logic [PIX_W-1:0] round_sat(input int unsigned v);
		int unsigned r;
		r = (v + (1 << (FRAC - 1))) >> FRAC;
		return (r > 255) ? 8'd255 : r[PIX_W-1:0];
	endfunction

	// Update the local background for one pixel and work out its answer
	function automatic answer_t background_answer(input rgb_t pix,
			input logic [INDEX_W-1:0] raw_idx, input logic is_last, input logic upd);
		int unsigned idx;
		int unsigned a;
		int unsigned p;
		int unsigned bg;
		int unsigned sum;
		fix_rgb_t    entry;
		answer_t     ans;
		idx = int'(raw_idx) % STORE_DEPTH;
		a   = (rate == 0) ? int'(DEFAULT_RATE) : int'(rate);
		ans = '0;
		sum = 0;
		if (bg_ready || upd) begin
			entry = bg_model.exists(idx) ? bg_model[idx] : '0;
			// copy during the first frame, blend afterwards
			if (upd) begin
				for (int c = 0; c < 3; c++) begin
					p  = int'(pix[c]) << FRAC;
					bg = 32'(entry[c]);
					if (bg_ready)
						entry[c] = 16'((bg * (256 - a) + p * a + 128) >> 8);
					else
						entry[c] = 16'(p);
				end
				bg_model[idx] = entry;
				if (!bg_ready && is_last)
					bg_ready = 1'b1;
			end
			// distance against the updated background
			for (int c = 0; c < 3; c++) begin
				p   = int'(pix[c]) << FRAC;
				bg  = 32'(entry[c]);
				sum += (bg > p) ? bg - p : p - bg;
				ans.colour[c] = round_sat(bg);
			end
			ans.distance = round_sat(sum);
			ans.ready    = 1'b1;
		end
		return ans;
	endfunction

	// Count a failure and show only the first few
	function automatic void report_fault(input string msg);
		fail_count++;
		if (fail_count <= SHOW_LIMIT)
			$display("[%0t] result mismatch: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t seen;
		answer_t want;
		if (!arst_n) begin
			pending_answers.delete();
			bg_ready     = 1'b0;
			rate         = DEFAULT_RATE;
			fail_count   = 0;
			answers_due  = 0;
			answers_seen = 0;
		end else begin
			// compare a taken result with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				seen = {m_axis_tuser, m_axis_tdata};
				answers_seen++;
				if (pending_answers.size() == 0) begin
					report_fault($sformatf("unexpected result dist %0d bg %0d/%0d/%0d ready %0b",
						seen.distance, seen.colour[0], seen.colour[1], seen.colour[2],
						seen.ready));
				end else begin
					want = pending_answers.pop_front();
					if (seen.distance !== want.distance || seen.colour !== want.colour ||
							seen.ready !== want.ready)
						report_fault($sformatf({
							"result %0d expected dist %0d bg %0d/%0d/%0d ready %0b, ",
							"got dist %0d bg %0d/%0d/%0d ready %0b"},
							answers_seen, want.distance, want.colour[0], want.colour[1],
							want.colour[2], want.ready, seen.distance, seen.colour[0],
							seen.colour[1], seen.colour[2], seen.ready));
				end
			end
			// track rate writes
			if (cfg_valid && cfg_ready)
				rate = cfg_data;
			// predict each accepted pixel request
			if (s_axis_tvalid && s_axis_tready)
				pending_answers.push_back(background_answer(s_axis_tdata[23:0],
					s_axis_tdata[42:24], s_axis_tlast, s_axis_tuser));
			answers_due = pending_answers.size();
		end
	end

endmodule

### dv/running_average_background_subtract_top_test.sv
// ---------------------------------------------------------------------------
// running_average_background_subtract_top_test
// Stream test of the running-average background subtractor.
// ---------------------------------------------------------------------------
// Resets the block, sends pixels before any background exists, stores a first
// frame over a pool of raster indices (the extremes among them), then mixes
// reads and blends on that pool under several blend rates, zero and the
// extremes included. Both stream sides pause at random, with bursts of no
// pausing. A separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module running_average_background_subtract_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rabs_pkg::*;

	localparam int DRAIN      = 16;
	localparam int PHASE_LEN  = 80;
	localparam int FILL_LEN   = 32;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [47:0]       s_axis_tdata;   // pixel_red, pixel_green, pixel_blue, pixel_index
	logic              s_axis_tlast;   // last_pixel
	logic              s_axis_tuser;   // update_background
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [31:0]       m_axis_tdata;   // distance, background_red, _green, _blue
	logic              m_axis_tuser;   // ready_res
	logic              cfg_valid;
	logic              cfg_ready;
	logic [RATE_W-1:0] cfg_data;

	int fail_count;
	int answers_due;
	int answers_seen;

	// Stimulus bookkeeping
	bit                 burst;
	bit                 frame_stored;
	bit                 stored_idx [int unsigned];
	int unsigned        bg_pool [$];
	int unsigned        last_idx;
	int                 pixels_sent;
	int                 updates_sent;
	int                 rate_writes;
	logic [RATE_W-1:0]  rate_plan [6];

	running_average_background_subtract_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	rabs_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.answers_due   (answers_due),
		.answers_seen  (answers_seen)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Overall time limit
	initial begin
		#5_000_000;
		$display("running_average_background_subtract_top_test: FAIL");
		$finish;
	end

	// Result side: stall for a drawn number of cycles before each result
	initial begin
		int stall;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = burst ? 0 : $urandom_range(0, 7);
			repeat (stall) begin
				@(negedge clk);
				m_axis_tready <= 1'b0;
			end
			@(negedge clk);
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
		end
	end

	function automatic rgb_t colour(input int r, input int g, input int b);
		rgb_t c;
		c[0] = r[PIX_W-1:0];
		c[1] = g[PIX_W-1:0];
		c[2] = b[PIX_W-1:0];
		return c;
	endfunction

	// Channel values leaning towards the extremes
	function automatic rgb_t random_colour();
		rgb_t c;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(0, 7))
				0:       c[i] = 8'd0;
				1:       c[i] = 8'd255;
				default: c[i] = PIX_W'($urandom_range(0, 255));
			endcase
		end
		return c;
	endfunction

	// Send one pixel request after a drawn gap and wait for it to be taken
	task automatic send_pixel(input rgb_t pix, input int unsigned idx,
			input bit is_last, input bit upd);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 7);
		repeat (gap) begin
			@(negedge clk);
			s_axis_tvalid <= 1'b0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {5'd0, idx[INDEX_W-1:0], pix};
		s_axis_tlast  <= is_last;
		s_axis_tuser  <= upd;
		do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
		pixels_sent++;
		last_idx = idx;
		// remember which entries the first frame has written
		if (upd) begin
			updates_sent++;
			if (!frame_stored && !stored_idx.exists(idx)) begin
				stored_idx[idx] = 1'b1;
				bg_pool.push_back(idx);
			end
			if (is_last)
				frame_stored = 1'b1;
		end
	endtask

	// Read or blend at a stored entry, often the one just used
	task automatic random_pixel();
		int unsigned idx;
		if ($urandom_range(0, 3) == 0)
			idx = last_idx;
		else
			idx = bg_pool[$urandom_range(0, bg_pool.size() - 1)];
		send_pixel(random_colour(), idx, $urandom_range(0, 15) == 0, $urandom_range(0, 1));
	endtask

	// Write the blend rate once every result has drained
	task automatic write_rate(input logic [RATE_W-1:0] value);
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (answers_due != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		cfg_valid <= 1'b0;
		rate_writes++;
	endtask

	// Stimulus and verdict
	initial begin
		int unsigned idx;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		s_axis_tuser  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		burst         = 1'b0;
		frame_stored  = 1'b0;
		last_idx      = 0;
		pixels_sent   = 0;
		updates_sent  = 0;
		rate_writes   = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// no background yet: plain pixels answer with zeros, last mark ignored
		send_pixel(colour(0, 0, 0), 0, 1'b0, 1'b0);
		send_pixel(colour(255, 255, 255), 19'h7FFFF, 1'b1, 1'b0);

		// first frame: copy pixels into their entries, extremes first
		send_pixel(colour(255, 255, 255), 0, 1'b0, 1'b1);
		send_pixel(colour(0, 0, 0), 19'h7FFFF, 1'b0, 1'b1);
		send_pixel(colour(12, 200, 77), 19'h2AAAA, 1'b0, 1'b1);
		burst = 1'b1;
		send_pixel(colour(128, 127, 1), 19'h55555, 1'b0, 1'b1);
		send_pixel(colour(9, 9, 9), 19'h55555, 1'b0, 1'b1);
		burst = 1'b0;

		// fill the rest of the frame, with plain pixels as noise
		repeat (FILL_LEN) begin
			if ($urandom_range(0, 3) == 0) begin
				send_pixel(random_colour(), $urandom_range(0, 19'h7FFFF), 1'b0, 1'b0);
			end else begin
				idx = ($urandom_range(0, 4) == 0) ? last_idx : $urandom_range(0, 19'h7FFFF);
				send_pixel(random_colour(), idx, 1'b0, 1'b1);
			end
		end
		send_pixel(random_colour(), 19'h2AAAA, 1'b1, 1'b1);

		// background present, default rate: saturated distance, blends both ways
		send_pixel(colour(0, 0, 0), 0, 1'b0, 1'b0);
		burst = 1'b1;
		send_pixel(colour(0, 0, 0), 0, 1'b0, 1'b1);
		send_pixel(colour(255, 255, 255), 19'h7FFFF, 1'b0, 1'b1);
		send_pixel(colour(255, 255, 255), 19'h7FFFF, 1'b0, 1'b1);
		burst = 1'b0;
		send_pixel(colour(9, 9, 9), 19'h55555, 1'b0, 1'b0);
		send_pixel(colour(40, 90, 250), 19'h2AAAA, 1'b1, 1'b1);

		// rate phases: extremes, zero for the default, then random settings
		rate_plan[0] = 8'd255;
		rate_plan[1] = 8'd1;
		rate_plan[2] = 8'd0;
		rate_plan[3] = RATE_W'($urandom_range(2, 254));
		rate_plan[4] = 8'd128;
		rate_plan[5] = RATE_W'($urandom_range(2, 254));
		foreach (rate_plan[p]) begin
			write_rate(rate_plan[p]);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (n % 20 == 0)
					burst = ($urandom_range(0, 3) == 0);
				random_pixel();
			end
		end
		burst = 1'b0;

		// drain the remaining results
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (answers_due != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);

		$display("Sent %0d pixels (%0d with background update) under %0d rate writes.",
			pixels_sent, updates_sent, rate_writes);
		$display("Checked %0d results against the predicted background, %0d failures.",
			answers_seen, fail_count);
		if (fail_count == 0)
			$display("running_average_background_subtract_top_test: PASS");
		else
			$display("running_average_background_subtract_top_test: FAIL");
		$finish;
	end

endmodule
